// ----- hw/rtl/lavb_pkg.sv -----
package lavb_pkg;

  localparam int COMP_W     = 32;
  localparam int M_W        = 30;
  localparam int SQRT_W     = 64;
  localparam int SQRT_STEPS = 32;
  localparam int LEN_W      = 32;

  typedef struct packed {
    logic valid;
    logic degen;
  } lavb_ctl_t;

  typedef enum logic [1:0] {
    ROW_LEFT,
    ROW_UP,
    ROW_FWD,
    ROW_TRANS
  } row_kind_e;

endpackage

// ----- hw/rtl/lavb_normalize.sv -----
module lavb_normalize #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  lavb_pkg::lavb_ctl_t           ctl_i,
  input  logic [2:0][IN_W-1:0]          vec_i,
  input  logic [SIDE_W-1:0]             side_i,
  output lavb_pkg::lavb_ctl_t           ctl_o,
  output logic [2:0][FRAC_BITS+1:0]     unit_o,
  output logic [SIDE_W-1:0]             side_o
);
  import lavb_pkg::*;

  localparam int LS    = $clog2(IN_W);
  localparam int QW    = FRAC_BITS + 1;
  localparam int UW    = FRAC_BITS + 2;
  localparam int DW    = FRAC_BITS + LEN_W + 1;
  localparam int SQ_W  = 2 * M_W;
  localparam int S_SET = LS + 3 + SQRT_STEPS;
  localparam int S_OUT = S_SET + QW + 1;
  localparam int NS    = S_OUT + 1;
  localparam int CW    = SIDE_W + 5;

  // carry word: side, degen in, zero, signs
  logic [NS-1:0]            vld_q;
  logic [CW-1:0]            car_q [NS];
  logic [CW-1:0]            car_d;
  logic [2:0][IN_W-1:0]     mag_d;
  logic [2:0]               neg_d;
  logic                     zero_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][IN_W-1];
      mag_d[i] = neg_d[i] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    zero_d = (vec_i == '0);
    car_d  = {side_i, ctl_i.degen, zero_d, neg_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_q[0] <= car_d;
      for (int k = 1; k < NS; k++) begin
        car_q[k] <= car_q[k-1];
      end
    end
  end

  // leading-zero alignment, largest shift first
  logic [2:0][IN_W-1:0] al_q   [LS+1];
  logic [IN_W-1:0]      alor_q [LS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      al_q[0]   <= mag_d;
      alor_q[0] <= mag_d[0] | mag_d[1] | mag_d[2];
    end
  end

  for (genvar j = 0; j < LS; j++) begin : g_align
    localparam int SH = 1 << (LS - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (alor_q[j][IN_W-1 -: SH] == '0) begin
          alor_q[j+1] <= alor_q[j] << SH;
          for (int i = 0; i < 3; i++) begin
            al_q[j+1][i] <= al_q[j][i] << SH;
          end
        end else begin
          alor_q[j+1] <= alor_q[j];
          al_q[j+1]   <= al_q[j];
        end
      end
    end
  end

  // squares and sum
  logic [2:0][M_W-1:0]  top_m;
  logic [2:0][M_W-1:0]  m_q  [SQRT_STEPS+2];
  logic [2:0][SQ_W-1:0] sq_q;
  logic [SQRT_W-1:0]    sn_q [SQRT_STEPS];
  logic [SQRT_W-1:0]    sr_q [SQRT_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      top_m[i] = al_q[LS][i][IN_W-1 -: M_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= top_m;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(top_m[i]) * SQ_W'(top_m[i]);
      end
      m_q[1]  <= m_q[0];
      sn_q[0] <= SQRT_W'(sq_q[0]) + SQRT_W'(sq_q[1]) + SQRT_W'(sq_q[2]);
      sr_q[0] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - t));
    logic [SQRT_W-1:0] trial;
    logic              take;
    assign trial = sr_q[t] + BIT;
    assign take  = (sn_q[t] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[t+1] <= take ? ((sr_q[t] >> 1) + BIT) : (sr_q[t] >> 1);
        m_q[t+2]  <= m_q[t+1];
      end
    end
    if (t < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sn_q[t+1] <= take ? (sn_q[t] - trial) : sn_q[t];
        end
      end
    end
  end

  // rounded division by the length, one quotient bit per stage
  logic [2:0][DW-1:0] rem_q [QW];
  logic [2:0][QW-1:0] q_q   [QW+1];
  logic [LEN_W-1:0]   dl_q  [QW];
  logic [LEN_W-1:0]   len;

  assign len = sr_q[SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= (DW'(m_q[SQRT_STEPS+1][i]) << FRAC_BITS) + DW'(len >> 1);
      end
      q_q[0]  <= '0;
      dl_q[0] <= len;
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int SB = QW - 1 - t;
    logic [DW-1:0] dsh;
    logic [2:0]    ge;
    assign dsh = DW'(dl_q[t]) << SB;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (rem_q[t][i] >= dsh);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          q_q[t+1][i] <= ge[i] ? (q_q[t][i] | (QW'(1) << SB)) : q_q[t][i];
        end
      end
    end
    if (t < QW - 1) begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dl_q[t+1] <= dl_q[t];
          for (int i = 0; i < 3; i++) begin
            rem_q[t+1][i] <= ge[i] ? (rem_q[t][i] - dsh) : rem_q[t][i];
          end
        end
      end
    end
  end

  // sign restore; a zero input vector gives a zero unit vector
  logic [2:0][UW-1:0] unit_q;
  logic [CW-1:0]      car_div;

  assign car_div = car_q[S_OUT-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (car_div[3]) begin
          unit_q[i] <= '0;
        end else if (car_div[i]) begin
          unit_q[i] <= ~UW'(q_q[QW][i]) + 1'b1;
        end else begin
          unit_q[i] <= UW'(q_q[QW][i]);
        end
      end
    end
  end

  assign unit_o      = unit_q;
  assign ctl_o.valid = vld_q[S_OUT];
  assign ctl_o.degen = car_q[S_OUT][4] | car_q[S_OUT][3];
  assign side_o      = car_q[S_OUT][CW-1:5];

endmodule

// ----- hw/rtl/look_at_view_basis_unit.sv -----
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_stall_o  eye_*, target_*, hint_* (signed Q)
// result    out        out_valid_o / out_stall_i row_kind, comp_a..c, degenerate, last
//
// Fully pipelined; a request can enter every cycle while the pipe has room.
// Each request yields four results, so the result port limits the sustained
// request rate; much of the depth comes from two 32-stage square roots.
// Reset clears valid bits and the output counter. A stall on the result
// side freezes the whole pipe once the final stage holds a result;
// nothing is dropped or repeated.
module look_at_view_basis_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lavb_pkg::COMP_W-1:0]  eye_x_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  eye_y_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  eye_z_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  target_x_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  target_y_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  target_z_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  hint_x_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  hint_y_i,
  input  logic signed [lavb_pkg::COMP_W-1:0]  hint_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          row_kind_o,
  output logic signed [lavb_pkg::COMP_W-1:0]  comp_a_o,
  output logic signed [lavb_pkg::COMP_W-1:0]  comp_b_o,
  output logic signed [lavb_pkg::COMP_W-1:0]  comp_c_o,
  output logic                                degenerate_o,
  output logic                                last_o
);
  import lavb_pkg::*;

  localparam int UW   = FRAC_BITS + 2;
  localparam int PW   = COMP_W + UW;
  localparam int LW   = PW + 1;
  localparam int XW   = 2 * UW;
  localparam int UPW  = FRAC_BITS + 5;
  localparam int DPW  = UPW + COMP_W;
  localparam int DSW  = DPW + 2;
  localparam int RW   = DSW - FRAC_BITS;
  localparam int NW   = RW + 1;
  localparam int S1_W = 6 * COMP_W;
  localparam int S2_W = 3 * UW + 3 * COMP_W;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  localparam logic [NW-1:0] SAT_HI = {{(NW-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
  localparam logic [NW-1:0] SAT_LO = {{(NW-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

  function automatic logic [COMP_W-1:0] sat32(input logic [NW-1:0] v);
    logic [COMP_W-1:0] r;
    if ($signed(v) > $signed(SAT_HI)) begin
      r = SAT_HI[COMP_W-1:0];
    end else if ($signed(v) < $signed(SAT_LO)) begin
      r = SAT_LO[COMP_W-1:0];
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic ser_take;

  logic t0_vld_q, c1_vld_q, c2_vld_q, u1_vld_q, u2_vld_q, d1_vld_q, d2_vld_q, fin_vld_q;

  // input stage: eye - target
  logic [2:0][COMP_W:0]   t0_diff_q;
  logic [2:0][COMP_W-1:0] t0_eye_q, t0_hint_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_diff_q[0] <= $signed(eye_x_i) - $signed(target_x_i);
      t0_diff_q[1] <= $signed(eye_y_i) - $signed(target_y_i);
      t0_diff_q[2] <= $signed(eye_z_i) - $signed(target_z_i);
      t0_eye_q     <= {eye_z_i, eye_y_i, eye_x_i};
      t0_hint_q    <= {hint_z_i, hint_y_i, hint_x_i};
    end
  end

  // forward axis
  lavb_ctl_t              n1_ctl_i, n1_ctl_o;
  logic [2:0][UW-1:0]     fwd1;
  logic [S1_W-1:0]        n1_side;
  logic [2:0][COMP_W-1:0] n1_eye, n1_hint;

  assign n1_ctl_i.valid = t0_vld_q;
  assign n1_ctl_i.degen = 1'b0;

  lavb_normalize #(
    .IN_W     (COMP_W + 1),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (S1_W)
  ) u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (n1_ctl_i),
    .vec_i  (t0_diff_q),
    .side_i ({t0_eye_q, t0_hint_q}),
    .ctl_o  (n1_ctl_o),
    .unit_o (fwd1),
    .side_o (n1_side)
  );

  assign n1_eye  = n1_side[S1_W-1 -: 3*COMP_W];
  assign n1_hint = n1_side[3*COMP_W-1:0];

  // hint x forward
  logic [5:0][PW-1:0]     c1_p_q;
  logic [2:0][UW-1:0]     c1_fwd_q, c2_fwd_q;
  logic [2:0][COMP_W-1:0] c1_eye_q, c2_eye_q;
  logic                   c1_deg_q, c2_deg_q;
  logic [2:0][LW-1:0]     c2_l_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_p_q[0] <= $signed(n1_hint[1]) * $signed(fwd1[2]);
      c1_p_q[1] <= $signed(n1_hint[2]) * $signed(fwd1[1]);
      c1_p_q[2] <= $signed(n1_hint[2]) * $signed(fwd1[0]);
      c1_p_q[3] <= $signed(n1_hint[0]) * $signed(fwd1[2]);
      c1_p_q[4] <= $signed(n1_hint[0]) * $signed(fwd1[1]);
      c1_p_q[5] <= $signed(n1_hint[1]) * $signed(fwd1[0]);
      c1_fwd_q  <= fwd1;
      c1_eye_q  <= n1_eye;
      c1_deg_q  <= n1_ctl_o.degen;
      for (int i = 0; i < 3; i++) begin
        c2_l_q[i] <= $signed(c1_p_q[2*i]) - $signed(c1_p_q[2*i+1]);
      end
      c2_fwd_q <= c1_fwd_q;
      c2_eye_q <= c1_eye_q;
      c2_deg_q <= c1_deg_q;
    end
  end

  // left axis
  lavb_ctl_t              n2_ctl_i, n2_ctl_o;
  logic [2:0][UW-1:0]     left2;
  logic [S2_W-1:0]        n2_side;
  logic [2:0][UW-1:0]     n2_fwd;
  logic [2:0][COMP_W-1:0] n2_eye;

  assign n2_ctl_i.valid = c2_vld_q;
  assign n2_ctl_i.degen = c2_deg_q;

  lavb_normalize #(
    .IN_W     (LW),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (S2_W)
  ) u_norm_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (n2_ctl_i),
    .vec_i  (c2_l_q),
    .side_i ({c2_fwd_q, c2_eye_q}),
    .ctl_o  (n2_ctl_o),
    .unit_o (left2),
    .side_o (n2_side)
  );

  assign n2_fwd = n2_side[S2_W-1 -: 3*UW];
  assign n2_eye = n2_side[3*COMP_W-1:0];

  // up = forward x left
  logic [5:0][XW-1:0]     u1_p_q;
  logic [2:0][UW-1:0]     u1_left_q, u1_fwd_q, u2_left_q, u2_fwd_q;
  logic [2:0][COMP_W-1:0] u1_eye_q, u2_eye_q;
  logic                   u1_deg_q, u2_deg_q;
  logic [2:0][XW:0]       u2_rnd;
  logic [2:0][UPW-1:0]    u2_up_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u2_rnd[i] = $signed(u1_p_q[2*i]) - $signed(u1_p_q[2*i+1]) + (XW+1)'(HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_p_q[0] <= $signed(n2_fwd[1]) * $signed(left2[2]);
      u1_p_q[1] <= $signed(n2_fwd[2]) * $signed(left2[1]);
      u1_p_q[2] <= $signed(n2_fwd[2]) * $signed(left2[0]);
      u1_p_q[3] <= $signed(n2_fwd[0]) * $signed(left2[2]);
      u1_p_q[4] <= $signed(n2_fwd[0]) * $signed(left2[1]);
      u1_p_q[5] <= $signed(n2_fwd[1]) * $signed(left2[0]);
      u1_left_q <= left2;
      u1_fwd_q  <= n2_fwd;
      u1_eye_q  <= n2_eye;
      u1_deg_q  <= n2_ctl_o.degen;
      for (int i = 0; i < 3; i++) begin
        u2_up_q[i] <= u2_rnd[i][XW:FRAC_BITS];
      end
      u2_left_q <= u1_left_q;
      u2_fwd_q  <= u1_fwd_q;
      u2_eye_q  <= u1_eye_q;
      u2_deg_q  <= u1_deg_q;
    end
  end

  // translation: -round(axis . eye)
  logic [2:0][2:0][DPW-1:0] d1_p_q;
  logic [2:0][UW-1:0]       d1_left_q, d1_fwd_q, d2_left_q, d2_fwd_q;
  logic [2:0][UPW-1:0]      d1_up_q, d2_up_q;
  logic                     d1_deg_q, d2_deg_q;
  logic [2:0][DSW-1:0]      d2_sum;
  logic [2:0][RW-1:0]       d2_rr_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d2_sum[k] = $signed(d1_p_q[k][0]) + $signed(d1_p_q[k][1]) + $signed(d1_p_q[k][2])
                + DSW'(HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_p_q[0][i] <= $signed(u2_left_q[i]) * $signed(u2_eye_q[i]);
        d1_p_q[1][i] <= $signed(u2_up_q[i]) * $signed(u2_eye_q[i]);
        d1_p_q[2][i] <= $signed(u2_fwd_q[i]) * $signed(u2_eye_q[i]);
        d2_rr_q[i]   <= d2_sum[i][DSW-1:FRAC_BITS];
      end
      d1_left_q <= u2_left_q;
      d1_up_q   <= u2_up_q;
      d1_fwd_q  <= u2_fwd_q;
      d1_deg_q  <= u2_deg_q;
      d2_left_q <= d1_left_q;
      d2_up_q   <= d1_up_q;
      d2_fwd_q  <= d1_fwd_q;
      d2_deg_q  <= d1_deg_q;
    end
  end

  // final rows
  logic [3:0][2:0][COMP_W-1:0] fin_q;
  logic                        fin_deg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_deg_q <= d2_deg_q;
      for (int i = 0; i < 3; i++) begin
        if (d2_deg_q) begin
          fin_q[ROW_LEFT][i]  <= '0;
          fin_q[ROW_UP][i]    <= '0;
          fin_q[ROW_FWD][i]   <= '0;
          fin_q[ROW_TRANS][i] <= '0;
        end else begin
          fin_q[ROW_LEFT][i]  <= COMP_W'($signed(d2_left_q[i]));
          fin_q[ROW_UP][i]    <= COMP_W'($signed(d2_up_q[i]));
          fin_q[ROW_FWD][i]   <= COMP_W'($signed(d2_fwd_q[i]));
          fin_q[ROW_TRANS][i] <= sat32(NW'(-NW'($signed(d2_rr_q[i]))));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_vld_q  <= 1'b0;
      c1_vld_q  <= 1'b0;
      c2_vld_q  <= 1'b0;
      u1_vld_q  <= 1'b0;
      u2_vld_q  <= 1'b0;
      d1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
    end else if (en) begin
      t0_vld_q  <= in_valid_i;
      c1_vld_q  <= n1_ctl_o.valid;
      c2_vld_q  <= c1_vld_q;
      u1_vld_q  <= n2_ctl_o.valid;
      u2_vld_q  <= u1_vld_q;
      d1_vld_q  <= u2_vld_q;
      d2_vld_q  <= d1_vld_q;
      fin_vld_q <= d2_vld_q;
    end
  end

  // result serializer
  logic                        ser_vld_q;
  logic                        ser_deg_q;
  logic [3:0][2:0][COMP_W-1:0] ser_q;
  row_kind_e                   cnt_q, cnt_next;

  always_comb begin
    case (cnt_q)
      ROW_LEFT: cnt_next = ROW_UP;
      ROW_UP:   cnt_next = ROW_FWD;
      ROW_FWD:  cnt_next = ROW_TRANS;
      default:  cnt_next = ROW_LEFT;
    endcase
  end

  assign ser_take   = !ser_vld_q || (cnt_q == ROW_TRANS && !out_stall_i);
  assign en         = !fin_vld_q || ser_take;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= ROW_LEFT;
    end else if (fin_vld_q && ser_take) begin
      ser_vld_q <= 1'b1;
      cnt_q     <= ROW_LEFT;
    end else if (ser_vld_q && !out_stall_i) begin
      if (cnt_q == ROW_TRANS) begin
        ser_vld_q <= 1'b0;
      end
      cnt_q <= cnt_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld_q && ser_take) begin
      ser_q     <= fin_q;
      ser_deg_q <= fin_deg_q;
    end
  end

  assign out_valid_o  = ser_vld_q;
  assign row_kind_o   = cnt_q;
  assign comp_a_o     = ser_q[cnt_q][0];
  assign comp_b_o     = ser_q[cnt_q][1];
  assign comp_c_o     = ser_q[cnt_q][2];
  assign degenerate_o = ser_deg_q;
  assign last_o       = (cnt_q == ROW_TRANS);

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && cnt_q == $past(cnt_next))
    else $error("result row did not advance");

  a_degen_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> degenerate_o == $past(degenerate_o))
    else $error("degenerate flag changed inside a request");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> comp_a_o == '0 && comp_b_o == '0 && comp_c_o == '0)
    else $error("degenerate result with nonzero components");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !en |=> fin_vld_q)
    else $error("stalled pipe lost its last stage");

endmodule

// ----- test/tb_look_at_view_basis_unit.sv -----
`timescale 1ns / 1ps

module tb_look_at_view_basis_unit;
  import lavb_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 * FRAC + 96;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    int eye[3];
    int tgt[3];
    int hint[3];
  } view_req_t;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] a, b, c;
    bit          degen, last;
  } basis_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] hint_x_i = '0, hint_y_i = '0, hint_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] row_kind_o;
  logic signed [31:0] comp_a_o, comp_b_o, comp_c_o;
  logic degenerate_o, last_o;

  basis_row_t pending_rows[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 21;
  bit recv_hold = 1'b0;

  look_at_view_basis_unit #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    basis_row_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected result row_kind=%0d", row_kind_o);
        errors++;
      end else begin
        e = pending_rows.pop_front();
        if (row_kind_o !== e.kind) begin
          $error("row_kind exp %0d got %0d", e.kind, row_kind_o); errors++;
        end
        if (comp_a_o !== e.a) begin
          $error("comp_a exp %h got %h", e.a, comp_a_o); errors++;
        end
        if (comp_b_o !== e.b) begin
          $error("comp_b exp %h got %h", e.b, comp_b_o); errors++;
        end
        if (comp_c_o !== e.c) begin
          $error("comp_c exp %h got %h", e.c, comp_c_o); errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, degenerate_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned mag[3], m, sum, len, q;
    bit neg[3];
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (m == 0) return 1'b0;
    while (m >= (64'h1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'h1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (len >> 1)) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic basis_row_t make_row(row_kind_e k, longint a, longint b, longint c,
                                          bit degen);
    basis_row_t r;
    r.kind = k;
    r.a = clamp32(a);
    r.b = clamp32(b);
    r.c = clamp32(c);
    r.degen = degen;
    r.last = (k == ROW_TRANS);
    return r;
  endfunction

  task automatic predict_basis(view_req_t rq);
    longint eye[3], hint[3], diff[3], fwd[3], lraw[3], left[3], up[3], tr[3], dot;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      eye[i] = rq.eye[i];
      hint[i] = rq.hint[i];
      diff[i] = eye[i] - longint'(rq.tgt[i]);
    end
    ok = unit_vec(diff, fwd);
    if (ok) begin
      lraw[0] = hint[1] * fwd[2] - hint[2] * fwd[1];
      lraw[1] = hint[2] * fwd[0] - hint[0] * fwd[2];
      lraw[2] = hint[0] * fwd[1] - hint[1] * fwd[0];
      ok = unit_vec(lraw, left);
    end
    if (!ok) begin
      pending_rows.push_back(make_row(ROW_LEFT, 0, 0, 0, 1'b1));
      pending_rows.push_back(make_row(ROW_UP, 0, 0, 0, 1'b1));
      pending_rows.push_back(make_row(ROW_FWD, 0, 0, 0, 1'b1));
      pending_rows.push_back(make_row(ROW_TRANS, 0, 0, 0, 1'b1));
      return;
    end
    up[0] = round_frac(fwd[1] * left[2] - fwd[2] * left[1]);
    up[1] = round_frac(fwd[2] * left[0] - fwd[0] * left[2]);
    up[2] = round_frac(fwd[0] * left[1] - fwd[1] * left[0]);
    dot = left[0] * eye[0] + left[1] * eye[1] + left[2] * eye[2];
    tr[0] = -round_frac(dot);
    dot = up[0] * eye[0] + up[1] * eye[1] + up[2] * eye[2];
    tr[1] = -round_frac(dot);
    dot = fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2];
    tr[2] = -round_frac(dot);
    pending_rows.push_back(make_row(ROW_LEFT, left[0], left[1], left[2], 1'b0));
    pending_rows.push_back(make_row(ROW_UP, up[0], up[1], up[2], 1'b0));
    pending_rows.push_back(make_row(ROW_FWD, fwd[0], fwd[1], fwd[2], 1'b0));
    pending_rows.push_back(make_row(ROW_TRANS, tr[0], tr[1], tr[2], 1'b0));
  endtask

  task automatic send_request(view_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    eye_x_i <= rq.eye[0];    eye_y_i <= rq.eye[1];    eye_z_i <= rq.eye[2];
    target_x_i <= rq.tgt[0]; target_y_i <= rq.tgt[1]; target_z_i <= rq.tgt[2];
    hint_x_i <= rq.hint[0];  hint_y_i <= rq.hint[1];  hint_z_i <= rq.hint[2];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_basis(rq);
  endtask

  task automatic finish_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  function automatic int rand_comp();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(0, 40 << FRAC)) - (20 << FRAC);
    endcase
  endfunction

  function automatic view_req_t rand_request();
    view_req_t rq;
    int sel;
    sel = $urandom_range(19);
    for (int i = 0; i < 3; i++) begin
      rq.eye[i] = rand_comp();
      rq.tgt[i] = rand_comp();
      rq.hint[i] = rand_comp();
    end
    if (sel == 0) rq.tgt = rq.eye;
    if (sel == 1) rq.hint = '{0, 0, 0};
    if (sel == 2) begin
      for (int i = 0; i < 3; i++) rq.hint[i] = rq.eye[i] / 2 - rq.tgt[i] / 2;
      rq.eye = '{3 << FRAC, -5 << FRAC, 7 << FRAC};
      rq.tgt = '{1 << FRAC, 1 << FRAC, 1 << FRAC};
      rq.hint = '{2 << FRAC, -6 << FRAC, 6 << FRAC};
    end
    return rq;
  endfunction

  function automatic view_req_t mk(int ex, int ey, int ez, int tx, int ty, int tz,
                                   int hx, int hy, int hz);
    view_req_t rq;
    rq.eye = '{ex, ey, ez};
    rq.tgt = '{tx, ty, tz};
    rq.hint = '{hx, hy, hz};
    return rq;
  endfunction

  task automatic test_directed();
    localparam int ONE = 1 << FRAC;
    localparam int MX = 32'sh7fffffff;
    localparam int MN = 32'sh80000000;
    send_request(mk(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    send_request(mk(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0));
    send_request(mk(0, 0, ONE, 0, 0, 0, 0, 0, 0));
    send_request(mk(0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE));
    send_request(mk(0, 0, ONE, 0, 0, 0, 0, 0, -ONE));
    send_request(mk(MX, MX, MX, MN, MN, MN, 0, ONE, 0));
    send_request(mk(MN, MN, MN, MX, MX, MX, MX, MN, MX));
    send_request(mk(MX, MN, MX, 0, 0, 0, ONE, 0, 0));
    send_request(mk(MN, 0, MX, MN, ONE, MX, MN, MN, 0));
    send_request(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(mk(-1, -1, -1, 0, 0, 0, 1, -1, 1));
    send_request(mk(MX, 0, 0, MX - 1, 0, 0, 0, 0, MX));
    send_request(mk(10 * ONE, 0, -10 * ONE, -3 * ONE, ONE, 2 * ONE, -ONE, ONE, 0));
    send_request(mk(MX, MX, MX, MX - ONE, MX, MX, 0, 0, MN));
    finish_sending();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      send_idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 21;
      recv_idle_pct = send_idle_pct;
      send_request(rand_request());
    end
    finish_sending();
    send_idle_pct = 21;
    recv_idle_pct = 21;
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int n = 0; n < 40; n++) send_request(rand_request());
        finish_sending();
      end
    join
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 6; n++) send_request(rand_request());
    finish_sending();
    wait_drained();
    for (int n = 0; n < 6; n++) send_request(rand_request());
    finish_sending();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120);
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (LATENCY + 100) @(posedge clk_i);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
